FILE: rtl/bdeq_pkg.sv
// Shared types, codes and ring arithmetic for the bounded double-ended queue.
`default_nettype none
package bdeq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int HELD_W   = 4;
  localparam int IN_TDW   = 40;
  localparam int OUT_TDW  = 40;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_ALL   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // (a + b) mod DEPTH for a, b below DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  // (a - 1) mod DEPTH
  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = a - IDX_W'(1);
    end
    return r;
  endfunction

  // fill count masked to the held_count field
  function automatic logic [HELD_W-1:0] to_held(input logic [CNT_W-1:0] cnt);
    logic [31:0] t;
    t = 32'(cnt);
    return t[HELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bdeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bdeq_front.sv
// Front end: takes input beats, drops unknown opcodes, queues commands.
`default_nettype none
module bdeq_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [bdeq_pkg::IN_TDW-1:0]   in_tdata,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output bdeq_pkg::cmd_t                     cmd
);

  localparam logic [1:0] Q_FULL = 2'd2;

  bdeq_pkg::cmd_t q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       known_op;
  logic       push;
  logic       pop;
  bdeq_pkg::cmd_t in_cmd;

  assign in_cmd.opcode = in_tdata[bdeq_pkg::OP_W-1:0];
  assign in_cmd.value  = in_tdata[bdeq_pkg::OP_W +: bdeq_pkg::VAL_W];

  assign known_op  = in_cmd.opcode <= bdeq_pkg::OP_READ_ALL;
  assign in_tready = cnt_r != Q_FULL;
  assign push      = in_tvalid && in_tready && known_op;
  assign cmd_valid = cnt_r != 2'd0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bdeq_back.sv
// Back end: ring pointers, entry store and result register.
`default_nettype none
module bdeq_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire bdeq_pkg::cmd_t                cmd,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [bdeq_pkg::OUT_TDW-1:0]       out_tdata,
  output logic                               out_tlast
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;
  localparam int   IW     = bdeq_pkg::IDX_W;
  localparam int   CW     = bdeq_pkg::CNT_W;

  logic          state_r, state_nxt;
  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_all_r, rd_all_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [bdeq_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [bdeq_pkg::VAL_W-1:0]      out_value_r, out_value_nxt;
  logic                            out_last_r, out_last_nxt;
  logic [bdeq_pkg::HELD_W-1:0]     out_held_r, out_held_nxt;

  logic                        ram_we, ram_re;
  logic [IW-1:0]               ram_waddr, ram_raddr;
  logic [bdeq_pkg::VAL_W-1:0]  ram_rdata;

  logic slot_free;
  logic is_full, is_empty;
  logic rd_last;

  bdeq_ram #(
    .WIDTH(bdeq_pkg::VAL_W),
    .DEPTH(bdeq_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cmd.value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign slot_free = !out_valid_r || out_tready;
  assign is_full   = fill_r == CW'(bdeq_pkg::DEPTH);
  assign is_empty  = fill_r == '0;
  assign rd_last   = !rd_all_r || (CW'(rd_idx_r) + CW'(1) == fill_r);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    fill_nxt       = fill_r;
    rd_idx_nxt     = rd_idx_r;
    rd_all_nxt     = rd_all_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_held_nxt   = out_held_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = front_r;
    ram_raddr      = front_r;
    cmd_ready      = 1'b0;

    case (state_r)
      S_IDLE: begin
        cmd_ready = slot_free;
        if (slot_free && cmd_valid) begin
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          out_held_nxt  = bdeq_pkg::to_held(fill_r);
          case (cmd.opcode)
            bdeq_pkg::OP_PUSH_FRONT, bdeq_pkg::OP_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = bdeq_pkg::ST_FULL;
              end else begin
                ram_we = 1'b1;
                if (cmd.opcode == bdeq_pkg::OP_PUSH_FRONT) begin
                  ram_waddr = bdeq_pkg::wrap_dec(front_r);
                  front_nxt = bdeq_pkg::wrap_dec(front_r);
                end else begin
                  ram_waddr = bdeq_pkg::wrap_add(front_r, IW'(fill_r));
                end
                fill_nxt       = fill_r + CW'(1);
                out_status_nxt = bdeq_pkg::ST_OK;
                out_held_nxt   = bdeq_pkg::to_held(fill_r + CW'(1));
              end
            end
            bdeq_pkg::OP_POP_FRONT, bdeq_pkg::OP_POP_BACK,
            bdeq_pkg::OP_READ_ALL: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bdeq_pkg::ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                state_nxt  = S_RD;
                rd_idx_nxt = '0;
                rd_all_nxt = cmd.opcode == bdeq_pkg::OP_READ_ALL;
                if (cmd.opcode == bdeq_pkg::OP_POP_FRONT) begin
                  fill_nxt  = fill_r - CW'(1);
                  front_nxt = (fill_r == CW'(1)) ? '0 :
                              bdeq_pkg::wrap_add(front_r, IW'(1));
                end else if (cmd.opcode == bdeq_pkg::OP_POP_BACK) begin
                  ram_raddr = bdeq_pkg::wrap_add(front_r, IW'(fill_r - CW'(1)));
                  fill_nxt  = fill_r - CW'(1);
                  if (fill_r == CW'(1)) begin
                    front_nxt = '0;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        // read data holds until the next read, so wait here on a stall
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bdeq_pkg::ST_OK;
          out_value_nxt  = ram_rdata;
          out_last_nxt   = rd_last;
          out_held_nxt   = bdeq_pkg::to_held(fill_r);
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = bdeq_pkg::wrap_add(front_r, rd_idx_r + IW'(1));
            rd_idx_nxt = rd_idx_r + IW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      rd_all_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_all_r    <= rd_all_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_held_r   <= out_held_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(bdeq_pkg::OUT_TDW - bdeq_pkg::STAT_W - bdeq_pkg::VAL_W
                        - bdeq_pkg::HELD_W){1'b0}},
                       out_held_r, out_value_r, out_status_r};

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(bdeq_pkg::DEPTH))
    else $error("fill count above depth");
  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r < IW'(bdeq_pkg::DEPTH - 1) || front_r == IW'(bdeq_pkg::DEPTH - 1))
    else $error("front index outside ring");
  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> front_r == '0)
    else $error("front index not home on empty store");
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD && rd_all_r |-> CW'(rd_idx_r) < fill_r)
    else $error("read-all scan past held values");
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE && !is_full)
    else $error("store write outside an accepted push");
`endif

endmodule
`default_nettype wire

FILE: rtl/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue: front end feeding the back end.
//
//  channel | dir | fields (tdata from bit 0 up)                    | tlast
//  in_     | in  | opcode[2:0], push_value[34:3], zero pad        | -
//  out_    | out | status[1:0], out_value[33:2], held_count[37:34] | last
//
// Push, refused push and any empty request: result registered in the cycle after
// the back end takes the command. Pop: entry RAM read register, then result
// register. Read all: one beat per cycle unless the output stalls. The back end
// takes the next command once its previous result is issued; the front end
// queues up to two beats meanwhile. Reset takes effect at once, no clearing
// pass. A stalled output holds its beat while the back end waits.
`default_nettype none
module bounded_double_ended_queue (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // opcode, push_value, zero pad
  input  wire logic [bdeq_pkg::IN_TDW-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // status, out_value, held_count, zero pad
  output logic [bdeq_pkg::OUT_TDW-1:0]      out_tdata,
  output logic                              out_tlast
);

  logic           cmd_valid;
  logic           cmd_ready;
  bdeq_pkg::cmd_t cmd;

  bdeq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  bdeq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire
